>>> design/terminal_key_sequence_decoder_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the terminal key sequence decoder
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_ASSERT_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TKSD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tksd: check failed");

// next-cycle implication
`define TKSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tksd: check failed");

`else

`define TKSD_ASSERT_SAME(label, clk, rst, ante, cons)
`define TKSD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> design/tksd_pkg.sv
// ---------------------------------------------------------------------------
// tksd_pkg
// Shared types and codes of the terminal key sequence decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package tksd_pkg;

   // result status
   typedef enum logic [1:0] {
      ST_UNSURE = 2'd0,
      ST_ENSURE = 2'd1,
      ST_FAIL   = 2'd2
   } status_type;

   // key codes
   localparam logic [4:0] KEY_NONE      = 5'd0;
   localparam logic [4:0] KEY_PRINTABLE = 5'd1;
   localparam logic [4:0] KEY_TAB       = 5'd2;
   localparam logic [4:0] KEY_BACKSPACE = 5'd3;
   localparam logic [4:0] KEY_ENTER     = 5'd4;
   localparam logic [4:0] KEY_ESCAPE    = 5'd5;
   localparam logic [4:0] KEY_ALT       = 5'd6;
   localparam logic [4:0] KEY_CTRLALT   = 5'd7;
   localparam logic [4:0] KEY_UP        = 5'd8;
   localparam logic [4:0] KEY_F1        = 5'd18;

   // offsets from a tilde-terminated step to its key code
   localparam logic [4:0] NAV_KEY_OFS = 5'd6;
   localparam logic [4:0] FN_KEY_OFS  = 5'd10;

   // bytes of interest
   localparam logic [7:0] BYTE_NUL   = 8'h00;
   localparam logic [7:0] BYTE_BS    = 8'h08;
   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_ESC   = 8'h1B;
   localparam logic [7:0] BYTE_DEL   = 8'h7F;
   localparam logic [7:0] BYTE_C2    = 8'hC2;
   localparam logic [7:0] BYTE_CSI   = 8'h5B;
   localparam logic [7:0] BYTE_SS3   = 8'h4F;
   localparam logic [7:0] BYTE_TILDE = 8'h7E;
   localparam logic [7:0] BYTE_SPACE = 8'h20;

   // sequence steps
   typedef enum logic [4:0] {
      STEP_IDLE = 5'd0,
      STEP_CR   = 5'd1,
      STEP_C2   = 5'd2,
      STEP_ESC  = 5'd3,
      STEP_CSI  = 5'd4,
      STEP_SS3  = 5'd5,
      STEP_T1   = 5'd6,
      STEP_T2   = 5'd7,
      STEP_T3   = 5'd8,
      STEP_T4   = 5'd9,
      STEP_T5   = 5'd10,
      STEP_T6   = 5'd11,
      STEP_F5   = 5'd12,
      STEP_F6   = 5'd13,
      STEP_F7   = 5'd14,
      STEP_F8   = 5'd15,
      STEP_F9   = 5'd16,
      STEP_F10  = 5'd17,
      STEP_F11  = 5'd18,
      STEP_F12  = 5'd19
   } step_type;

   // one accepted input item
   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } item_type;

   // one result item
   typedef struct packed {
      status_type status;
      logic [4:0] key_code;
      logic [7:0] extra_char;
   } result_type;

endpackage

`default_nettype wire

>>> design/tksd_req_if.sv
// ---------------------------------------------------------------------------
// tksd_req_if
// Input channel: valid/ready with one terminal byte or end mark.
// ---------------------------------------------------------------------------
`default_nettype none

interface tksd_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

`default_nettype wire

>>> design/tksd_rsp_if.sv
// ---------------------------------------------------------------------------
// tksd_rsp_if
// Result channel: valid/ready with one decoded key event.
// ---------------------------------------------------------------------------
`default_nettype none

interface tksd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [4:0] key_code;
   logic [7:0] extra_char;

   modport source (output valid, output status, output key_code, output extra_char,
                   input ready);
   modport sink   (input valid, input status, input key_code, input extra_char,
                   output ready);
endinterface

`default_nettype wire

>>> design/terminal_key_sequence_decoder.sv
// ---------------------------------------------------------------------------
// terminal_key_sequence_decoder
// Turns terminal bytes and end marks into key events, one result per item.
// ---------------------------------------------------------------------------
//  channel    dir   handshake     payload
//  req_chan   in    valid/ready   kind, data_byte
//  rsp_chan   out   valid/ready   status, key_code, extra_char
//
//  One item per cycle sustained while rsp_chan is not stalled; an item passes
//  through the input register, the decode and the result register, so its
//  result is registered before it can transfer out.
//  The sequence step register is the only loop in the decode.
//  Synchronous reset empties both registers and returns the step to idle.
//  A stalled result holds the input register; while a result waits, the
//  input register still takes one item if it is empty.
// ---------------------------------------------------------------------------
`default_nettype none

`include "terminal_key_sequence_decoder_assert.svh"

module terminal_key_sequence_decoder (
   input  wire logic  clock,
   input  wire logic  reset,
   tksd_req_if.sink   req_chan,
   tksd_rsp_if.source rsp_chan
);

   logic                 item_valid;
   tksd_pkg::item_type   item;
   logic                 room;
   logic                 fire;
   tksd_pkg::result_type result;
   tksd_pkg::step_type   step;

   // decode when an item is held and the result register can take it
   assign fire = item_valid && room;

   tksd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .pull       (room),
      .item_valid (item_valid),
      .item       (item)
   );

   tksd_decoder u_dec (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (result),
      .step   (step)
   );

   tksd_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (fire),
      .result   (result),
      .rsp_chan (rsp_chan),
      .room     (room)
   );

   // a final result always leaves the decoder idle
   `TKSD_ASSERT_NEXT(a_final_goes_idle, clock, reset,
      fire && result.status != tksd_pkg::ST_UNSURE, step == tksd_pkg::STEP_IDLE)

   // an incomplete sequence never leaves the decoder idle
   `TKSD_ASSERT_NEXT(a_unsure_busy, clock, reset,
      fire && result.status == tksd_pkg::ST_UNSURE, step != tksd_pkg::STEP_IDLE)

   // only a decoded key carries a key code
   `TKSD_ASSERT_SAME(a_key_only_on_ensure, clock, reset,
      result.status != tksd_pkg::ST_ENSURE, result.key_code == tksd_pkg::KEY_NONE)

   // a held item is not lost while the result side stalls
   `TKSD_ASSERT_NEXT(a_item_held, clock, reset,
      item_valid && !room, item_valid && $stable(item))

endmodule

`default_nettype wire

>>> design/tksd_in_stage.sv
// ---------------------------------------------------------------------------
// tksd_in_stage
// Input register: captures one item per transfer, hands it on when pulled.
// ---------------------------------------------------------------------------
`default_nettype none

module tksd_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   tksd_req_if.sink               req_chan,
   input  wire logic              pull,
   output logic                   item_valid,
   output tksd_pkg::item_type     item
);

   logic                 valid_ff, valid_in;
   tksd_pkg::item_type   item_ff;
   logic                 take;

   // free, or emptying this cycle
   assign req_chan.ready = !valid_ff || pull;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (pull) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.kind      <= req_chan.kind;
         item_ff.data_byte <= req_chan.data_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

>>> design/tksd_decoder.sv
// ---------------------------------------------------------------------------
// tksd_decoder
// Sequence step register and the one-step decode of a byte or end mark.
// ---------------------------------------------------------------------------
`default_nettype none

module tksd_decoder (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire tksd_pkg::item_type item,
   output tksd_pkg::result_type   result,
   output tksd_pkg::step_type     step
);

   tksd_pkg::step_type   step_ff, step_in;
   tksd_pkg::result_type res;
   logic [7:0]           b;

   function automatic logic is_printable(input logic [7:0] v);
      return (v >= tksd_pkg::BYTE_SPACE) && (v < tksd_pkg::BYTE_DEL);
   endfunction

   assign b = item.data_byte;

   // next step and result; default is fail back to idle
   always_comb begin
      res.status     = tksd_pkg::ST_FAIL;
      res.key_code   = tksd_pkg::KEY_NONE;
      res.extra_char = 8'h00;
      step_in        = tksd_pkg::STEP_IDLE;

      if (item.kind) begin
         // end mark
         if (step_ff == tksd_pkg::STEP_ESC) begin
            res.status   = tksd_pkg::ST_ENSURE;
            res.key_code = tksd_pkg::KEY_ESCAPE;
         end else if (step_ff == tksd_pkg::STEP_CR) begin
            res.status   = tksd_pkg::ST_ENSURE;
            res.key_code = tksd_pkg::KEY_ENTER;
         end
      end else begin
         case (step_ff)
            tksd_pkg::STEP_IDLE: begin
               if (b == tksd_pkg::BYTE_TAB) begin
                  res.status   = tksd_pkg::ST_ENSURE;
                  res.key_code = tksd_pkg::KEY_TAB;
               end else if (b == tksd_pkg::BYTE_DEL || b == tksd_pkg::BYTE_BS) begin
                  res.status   = tksd_pkg::ST_ENSURE;
                  res.key_code = tksd_pkg::KEY_BACKSPACE;
               end else if (b == tksd_pkg::BYTE_CR) begin
                  res.status = tksd_pkg::ST_UNSURE;
                  step_in    = tksd_pkg::STEP_CR;
               end else if (b == tksd_pkg::BYTE_LF) begin
                  res.status   = tksd_pkg::ST_ENSURE;
                  res.key_code = tksd_pkg::KEY_ENTER;
               end else if (b == tksd_pkg::BYTE_ESC) begin
                  res.status = tksd_pkg::ST_UNSURE;
                  step_in    = tksd_pkg::STEP_ESC;
               end else if (b == tksd_pkg::BYTE_C2) begin
                  res.status = tksd_pkg::ST_UNSURE;
                  step_in    = tksd_pkg::STEP_C2;
               end else if (is_printable(b)) begin
                  res.status     = tksd_pkg::ST_ENSURE;
                  res.key_code   = tksd_pkg::KEY_PRINTABLE;
                  res.extra_char = b;
               end
            end
            tksd_pkg::STEP_CR: begin
               if (b == tksd_pkg::BYTE_NUL || b == tksd_pkg::BYTE_LF) begin
                  res.status   = tksd_pkg::ST_ENSURE;
                  res.key_code = tksd_pkg::KEY_ENTER;
               end
            end
            tksd_pkg::STEP_C2: begin
               // shifted lowercase letter
               if (b >= 8'h81 && b <= 8'h9A) begin
                  res.status     = tksd_pkg::ST_ENSURE;
                  res.key_code   = tksd_pkg::KEY_CTRLALT;
                  res.extra_char = b - tksd_pkg::BYTE_SPACE;
               end
            end
            tksd_pkg::STEP_ESC: begin
               if (b == tksd_pkg::BYTE_CSI) begin
                  res.status = tksd_pkg::ST_UNSURE;
                  step_in    = tksd_pkg::STEP_CSI;
               end else if (b == tksd_pkg::BYTE_SS3) begin
                  res.status = tksd_pkg::ST_UNSURE;
                  step_in    = tksd_pkg::STEP_SS3;
               end else if (is_printable(b)) begin
                  res.status     = tksd_pkg::ST_ENSURE;
                  res.key_code   = tksd_pkg::KEY_ALT;
                  res.extra_char = b;
               end
            end
            tksd_pkg::STEP_CSI: begin
               // arrows A..D, or first digit 1..6
               if (b >= 8'h41 && b <= 8'h44) begin
                  res.status   = tksd_pkg::ST_ENSURE;
                  res.key_code = tksd_pkg::KEY_UP + 5'(b - 8'h41);
               end else if (b >= 8'h31 && b <= 8'h36) begin
                  res.status = tksd_pkg::ST_UNSURE;
                  step_in    = tksd_pkg::step_type'(5'(tksd_pkg::STEP_T1) + 5'(b - 8'h31));
               end
            end
            tksd_pkg::STEP_SS3: begin
               if (b >= 8'h50 && b <= 8'h53) begin
                  res.status   = tksd_pkg::ST_ENSURE;
                  res.key_code = tksd_pkg::KEY_F1 + 5'(b - 8'h50);
               end
            end
            tksd_pkg::STEP_T1, tksd_pkg::STEP_T2, tksd_pkg::STEP_T3,
            tksd_pkg::STEP_T4, tksd_pkg::STEP_T5, tksd_pkg::STEP_T6,
            tksd_pkg::STEP_F5, tksd_pkg::STEP_F6, tksd_pkg::STEP_F7,
            tksd_pkg::STEP_F8, tksd_pkg::STEP_F9, tksd_pkg::STEP_F10,
            tksd_pkg::STEP_F11, tksd_pkg::STEP_F12: begin
               if (b == tksd_pkg::BYTE_TILDE) begin
                  res.status = tksd_pkg::ST_ENSURE;
                  if (step_ff <= tksd_pkg::STEP_T6) begin
                     res.key_code = 5'(step_ff) + tksd_pkg::NAV_KEY_OFS;
                  end else begin
                     res.key_code = 5'(step_ff) + tksd_pkg::FN_KEY_OFS;
                  end
               end else if (step_ff == tksd_pkg::STEP_T1) begin
                  // ESC [ 1 x : F5..F8
                  res.status = tksd_pkg::ST_UNSURE;
                  if (b == 8'h35) begin
                     step_in = tksd_pkg::STEP_F5;
                  end else if (b == 8'h37) begin
                     step_in = tksd_pkg::STEP_F6;
                  end else if (b == 8'h38) begin
                     step_in = tksd_pkg::STEP_F7;
                  end else if (b == 8'h39) begin
                     step_in = tksd_pkg::STEP_F8;
                  end else begin
                     res.status = tksd_pkg::ST_FAIL;
                  end
               end else if (step_ff == tksd_pkg::STEP_T2) begin
                  // ESC [ 2 x : F9..F12
                  res.status = tksd_pkg::ST_UNSURE;
                  if (b == 8'h30) begin
                     step_in = tksd_pkg::STEP_F9;
                  end else if (b == 8'h31) begin
                     step_in = tksd_pkg::STEP_F10;
                  end else if (b == 8'h33) begin
                     step_in = tksd_pkg::STEP_F11;
                  end else if (b == 8'h34) begin
                     step_in = tksd_pkg::STEP_F12;
                  end else begin
                     res.status = tksd_pkg::ST_FAIL;
                  end
               end
            end
            default: begin
               // unused step codes: fail and go idle
               step_in = tksd_pkg::STEP_IDLE;
            end
         endcase
      end
   end

   // step register moves only when an item is decoded
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= tksd_pkg::STEP_IDLE;
      end else if (fire) begin
         step_ff <= step_in;
      end
   end

   assign result = res;
   assign step   = step_ff;

endmodule

`default_nettype wire

>>> design/tksd_out_stage.sv
// ---------------------------------------------------------------------------
// tksd_out_stage
// Result register driving the response channel.
// ---------------------------------------------------------------------------
`default_nettype none

module tksd_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire tksd_pkg::result_type result,
   tksd_rsp_if.source                rsp_chan,
   output logic                      room
);

   logic                  valid_ff, valid_in;
   tksd_pkg::result_type  result_ff;

   // empty, or being emptied this cycle
   assign room = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.status     = result_ff.status;
   assign rsp_chan.key_code   = result_ff.key_code;
   assign rsp_chan.extra_char = result_ff.extra_char;

endmodule

`default_nettype wire

>>> bench/tb_terminal_key_sequence_decoder.sv
// ---------------------------------------------------------------------------
// tb_terminal_key_sequence_decoder
// Self-checking bench for the terminal key sequence decoder. A directed run
// of the special keys is followed by random key sequences, some of them cut
// short or mixed with noise. Every input transfer is decoded by a model of
// the block kept in a scoreboard, and every result transfer is compared
// field by field with the oldest pending key event. The sender works in
// bursts and the receiver stalls on its own changing pattern.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_terminal_key_sequence_decoder;
   import tksd_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1450;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int unsigned REPORT_LIMIT = 25;

   // printable bytes that steer the escape sequences
   localparam logic [7:0] CHAR_0 = 8'h30;
   localparam logic [7:0] CHAR_1 = 8'h31;
   localparam logic [7:0] CHAR_6 = 8'h36;
   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_D = 8'h44;
   localparam logic [7:0] CHAR_P = 8'h50;
   localparam logic [7:0] CHAR_S = 8'h53;
   // range of the byte after 0xC2 that gives ctrl-alt
   localparam logic [7:0] CTRLALT_LO = 8'h81;
   localparam logic [7:0] CTRLALT_HI = 8'h9A;

   // receiver stall patterns
   typedef enum int unsigned {
      RX_OPEN,
      RX_RANDOM,
      RX_PERIODIC,
      RX_BURSTY
   } rx_pattern_type;

   // -------------------------------------------------------------------------
   // Scoreboard: decodes each transfer in and checks each transfer out
   // -------------------------------------------------------------------------
   class key_event_scoreboard;
      step_type    step;
      result_type  pending_events[$];
      int unsigned error_count;

      function new();
         step        = STEP_IDLE;
         error_count = 0;
      endfunction

      function result_type make_event(status_type s, logic [4:0] k, logic [7:0] c);
         result_type ev;
         ev.status     = s;
         ev.key_code   = k;
         ev.extra_char = c;
         return ev;
      endfunction

      // sequence goes on: remember the step, report unsure
      function result_type hold(step_type n);
         step = n;
         return make_event(ST_UNSURE, KEY_NONE, 8'h00);
      endfunction

      function bit printable(logic [7:0] b);
         return b >= BYTE_SPACE && b < BYTE_DEL;
      endfunction

      // one step of the decoder; anything not matched is a fail back to idle
      function result_type decode_key(item_type it);
         result_type ev;
         step_type   cur;
         logic [7:0] b;
         cur  = step;
         b    = it.data_byte;
         step = STEP_IDLE;
         ev   = make_event(ST_FAIL, KEY_NONE, 8'h00);
         if (it.kind) begin
            // end mark: only a lone ESC or a lone CR completes
            if (cur == STEP_ESC)
               ev = make_event(ST_ENSURE, KEY_ESCAPE, 8'h00);
            else if (cur == STEP_CR)
               ev = make_event(ST_ENSURE, KEY_ENTER, 8'h00);
         end else begin
            case (cur)
               STEP_IDLE: begin
                  if (b == BYTE_TAB)
                     ev = make_event(ST_ENSURE, KEY_TAB, 8'h00);
                  else if (b == BYTE_DEL || b == BYTE_BS)
                     ev = make_event(ST_ENSURE, KEY_BACKSPACE, 8'h00);
                  else if (b == BYTE_CR)
                     ev = hold(STEP_CR);
                  else if (b == BYTE_LF)
                     ev = make_event(ST_ENSURE, KEY_ENTER, 8'h00);
                  else if (b == BYTE_ESC)
                     ev = hold(STEP_ESC);
                  else if (b == BYTE_C2)
                     ev = hold(STEP_C2);
                  else if (printable(b))
                     ev = make_event(ST_ENSURE, KEY_PRINTABLE, b);
               end
               STEP_CR: begin
                  if (b == BYTE_NUL || b == BYTE_LF)
                     ev = make_event(ST_ENSURE, KEY_ENTER, 8'h00);
               end
               STEP_C2: begin
                  if (b >= CTRLALT_LO && b <= CTRLALT_HI)
                     ev = make_event(ST_ENSURE, KEY_CTRLALT, b - BYTE_SPACE);
               end
               STEP_ESC: begin
                  if (b == BYTE_CSI)
                     ev = hold(STEP_CSI);
                  else if (b == BYTE_SS3)
                     ev = hold(STEP_SS3);
                  else if (printable(b))
                     ev = make_event(ST_ENSURE, KEY_ALT, b);
               end
               STEP_CSI: begin
                  if (b >= CHAR_A && b <= CHAR_D)
                     ev = make_event(ST_ENSURE, KEY_UP + 5'(b - CHAR_A), 8'h00);
                  else if (b >= CHAR_1 && b <= CHAR_6)
                     ev = hold(step_type'(5'(STEP_T1) + 5'(b - CHAR_1)));
               end
               STEP_SS3: begin
                  if (b >= CHAR_P && b <= CHAR_S)
                     ev = make_event(ST_ENSURE, KEY_F1 + 5'(b - CHAR_P), 8'h00);
               end
               default: begin
                  // numbered sequences waiting for a second digit or the tilde
                  if (cur >= STEP_T1 && cur <= STEP_F12) begin
                     if (b == BYTE_TILDE)
                        ev = make_event(ST_ENSURE, (cur <= STEP_T6) ?
                                        5'(cur) + NAV_KEY_OFS : 5'(cur) + FN_KEY_OFS,
                                        8'h00);
                     else if (cur == STEP_T1) begin
                        if (b == CHAR_0 + 8'd5)
                           ev = hold(STEP_F5);
                        else if (b >= CHAR_0 + 8'd7 && b <= CHAR_0 + 8'd9)
                           ev = hold(step_type'(5'(STEP_F6) + 5'(b - (CHAR_0 + 8'd7))));
                     end else if (cur == STEP_T2) begin
                        if (b == CHAR_0)
                           ev = hold(STEP_F9);
                        else if (b == CHAR_1)
                           ev = hold(STEP_F10);
                        else if (b == CHAR_0 + 8'd3)
                           ev = hold(STEP_F11);
                        else if (b == CHAR_0 + 8'd4)
                           ev = hold(STEP_F12);
                     end
                  end
               end
            endcase
         end
         return ev;
      endfunction

      function void note_keystroke(item_type it);
         pending_events.push_back(decode_key(it));
      endfunction

      function void flag_mismatch(string field, int unsigned want, int unsigned got);
         if (error_count < REPORT_LIMIT)
            $error("key event %s: expected %0d, got %0d", field, want, got);
         error_count++;
      endfunction

      function void check_key_event(result_type got);
         result_type want;
         if (pending_events.size() == 0) begin
            if (error_count < REPORT_LIMIT)
               $error("key event with none pending: status %0d key_code %0d extra_char %0d",
                      got.status, got.key_code, got.extra_char);
            error_count++;
         end else begin
            want = pending_events.pop_front();
            if (got.status != want.status)
               flag_mismatch("status", want.status, got.status);
            if (got.key_code != want.key_code)
               flag_mismatch("key_code", want.key_code, got.key_code);
            if (got.extra_char != want.extra_char)
               flag_mismatch("extra_char", want.extra_char, got.extra_char);
         end
      endfunction

      function int unsigned pending();
         return pending_events.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, channels and the block
   // -------------------------------------------------------------------------
   logic clock;
   logic reset;

   tksd_req_if req_bus ();
   tksd_rsp_if rsp_bus ();

   terminal_key_sequence_decoder u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   key_event_scoreboard key_events = new();
   item_type            stim_q[$];
   int unsigned         cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** terminal_key_sequence_decoder: FAILED **");
         $finish;
      end
   end

   // watch both channels; values sampled here are the ones before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            key_events.note_keystroke({req_bus.kind, req_bus.data_byte});
         if (rsp_bus.valid && rsp_bus.ready)
            key_events.check_key_event({rsp_bus.status, rsp_bus.key_code,
                                        rsp_bus.extra_char});
      end
   end

   // receiver: picks a new stall pattern whenever the current one runs out
   initial begin
      rx_pattern_type pattern;
      int unsigned    pattern_left;
      int unsigned    phase;
      pattern       = RX_OPEN;
      pattern_left  = 0;
      phase         = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (pattern_left == 0) begin
            pattern      = rx_pattern_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(50, 300);
            phase        = 0;
         end
         pattern_left--;
         phase++;
         case (pattern)
            RX_OPEN:     rsp_bus.ready <= 1'b1;
            RX_RANDOM:   rsp_bus.ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: rsp_bus.ready <= (phase % 5) < 3;
            default:     rsp_bus.ready <= (phase % 24) >= 18;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   function automatic item_type byte_item(logic [7:0] b);
      return {1'b0, b};
   endfunction

   // end mark; the byte field is don't-care, so it is left random
   function automatic item_type end_item();
      return {1'b1, 8'($urandom)};
   endfunction

   // one key sequence, mostly well formed; some are cut short and broken
   task automatic add_random_sequence();
      item_type    seq[$];
      int unsigned pick;
      int unsigned cut;
      int unsigned fn_idx;
      logic [7:0]  fn_units [8];
      fn_units = '{8'h35, 8'h37, 8'h38, 8'h39, 8'h30, 8'h31, 8'h33, 8'h34};
      pick     = $urandom_range(0, 99);
      if (pick < 14) begin
         seq.push_back(byte_item(8'($urandom_range(BYTE_SPACE, BYTE_TILDE))));
      end else if (pick < 22) begin
         case ($urandom_range(0, 3))
            0:       seq.push_back(byte_item(BYTE_TAB));
            1:       seq.push_back(byte_item(BYTE_BS));
            2:       seq.push_back(byte_item(BYTE_DEL));
            default: seq.push_back(byte_item(BYTE_LF));
         endcase
      end else if (pick < 30) begin
         seq.push_back(byte_item(BYTE_CR));
         case ($urandom_range(0, 3))
            0:       seq.push_back(byte_item(BYTE_NUL));
            1:       seq.push_back(byte_item(BYTE_LF));
            2:       seq.push_back(end_item());
            default: seq.push_back(byte_item(8'($urandom)));
         endcase
      end else if (pick < 40) begin
         seq.push_back(byte_item(BYTE_ESC));
         case ($urandom_range(0, 3))
            0, 1:    seq.push_back(byte_item(8'($urandom_range(BYTE_SPACE, BYTE_TILDE))));
            2:       seq.push_back(end_item());
            default: seq.push_back(byte_item(8'($urandom)));
         endcase
      end else if (pick < 48) begin
         seq.push_back(byte_item(BYTE_C2));
         if ($urandom_range(0, 4) != 0)
            seq.push_back(byte_item(8'($urandom_range(CTRLALT_LO, CTRLALT_HI))));
         else
            seq.push_back(byte_item(8'($urandom)));
      end else if (pick < 57) begin
         seq.push_back(byte_item(BYTE_ESC));
         seq.push_back(byte_item(BYTE_CSI));
         seq.push_back(byte_item(8'($urandom_range(CHAR_A, CHAR_D))));
      end else if (pick < 63) begin
         seq.push_back(byte_item(BYTE_ESC));
         seq.push_back(byte_item(BYTE_SS3));
         seq.push_back(byte_item(8'($urandom_range(CHAR_P, CHAR_S))));
      end else if (pick < 72) begin
         seq.push_back(byte_item(BYTE_ESC));
         seq.push_back(byte_item(BYTE_CSI));
         seq.push_back(byte_item(8'($urandom_range(CHAR_1, CHAR_6))));
         seq.push_back(byte_item(BYTE_TILDE));
      end else if (pick < 82) begin
         // F5 to F12: ESC [ 1x ~ or ESC [ 2x ~
         fn_idx = $urandom_range(0, 7);
         seq.push_back(byte_item(BYTE_ESC));
         seq.push_back(byte_item(BYTE_CSI));
         seq.push_back(byte_item(fn_idx < 4 ? CHAR_1 : CHAR_1 + 8'd1));
         seq.push_back(byte_item(fn_units[fn_idx]));
         seq.push_back(byte_item(BYTE_TILDE));
      end else begin
         // line noise
         if ($urandom_range(0, 9) < 7)
            seq.push_back(byte_item(8'($urandom)));
         else
            seq.push_back(end_item());
      end
      // break some multi-byte sequences part way through
      if (seq.size() > 1 && $urandom_range(0, 4) == 0) begin
         cut = $urandom_range(1, seq.size() - 1);
         while (seq.size() > cut)
            void'(seq.pop_back());
         if ($urandom_range(0, 3) == 0)
            seq.push_back(end_item());
         else
            seq.push_back(byte_item(8'($urandom)));
      end
      foreach (seq[i])
         stim_q.push_back(seq[i]);
   endtask

   // hold one transfer on the input channel until it is taken
   task automatic send_keystroke(input item_type it);
      req_bus.valid     <= 1'b1;
      req_bus.kind      <= it.kind;
      req_bus.data_byte <= it.data_byte;
      do
         @(posedge clock);
      while (!req_bus.ready);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int unsigned directed_count;
      int unsigned burst_left;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.kind      = 1'b0;
      req_bus.data_byte = 8'h00;
      burst_left        = 0;

      // directed: single keys, enter forms, lone ESC/CR at end, escape forms
      stim_q.push_back(byte_item(BYTE_TAB));
      stim_q.push_back(byte_item(BYTE_DEL));
      stim_q.push_back(byte_item(BYTE_BS));
      stim_q.push_back(byte_item(BYTE_LF));
      stim_q.push_back(byte_item(BYTE_CR));
      stim_q.push_back(byte_item(BYTE_NUL));
      stim_q.push_back(byte_item(BYTE_CR));
      stim_q.push_back(end_item());
      stim_q.push_back(byte_item(BYTE_CR));
      stim_q.push_back(byte_item(CHAR_A));
      stim_q.push_back(byte_item(BYTE_ESC));
      stim_q.push_back(end_item());
      stim_q.push_back(byte_item(BYTE_ESC));
      stim_q.push_back(byte_item(BYTE_TILDE));
      stim_q.push_back(byte_item(BYTE_ESC));
      stim_q.push_back(byte_item(BYTE_CSI));
      stim_q.push_back(byte_item(CHAR_A));
      stim_q.push_back(byte_item(BYTE_ESC));
      stim_q.push_back(byte_item(BYTE_SS3));
      stim_q.push_back(byte_item(CHAR_S));
      stim_q.push_back(byte_item(BYTE_C2));
      stim_q.push_back(byte_item(CTRLALT_HI));
      stim_q.push_back(byte_item(BYTE_SPACE));
      stim_q.push_back(byte_item(8'hFF));
      stim_q.push_back(end_item());
      stim_q.push_back(byte_item(BYTE_ESC));
      stim_q.push_back(byte_item(BYTE_CSI));
      stim_q.push_back(byte_item(CHAR_1 + 8'd1));
      stim_q.push_back(byte_item(CHAR_0 + 8'd4));
      stim_q.push_back(byte_item(BYTE_TILDE));
      directed_count = stim_q.size();

      while (stim_q.size() < directed_count + RANDOM_ITEMS)
         add_random_sequence();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // sender: bursts of random length, usually preceded by a gap
      foreach (stim_q[i]) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
               req_bus.valid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end
         end
         send_keystroke(stim_q[i]);
         burst_left--;
      end
      req_bus.valid <= 1'b0;

      // let the last transfer reach the scoreboard, then drain
      @(posedge clock);
      while (key_events.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (key_events.pending() != 0)
         $error("%0d key events never arrived", key_events.pending());
      if (key_events.error_count == 0 && key_events.pending() == 0) begin
         $display("** terminal_key_sequence_decoder: PASSED **");
      end else begin
         $display("** terminal_key_sequence_decoder: FAILED **");
      end
      $finish;
   end

endmodule
